// ===== design/kfr_pkg.sv =====
// ----------------------------------------------------------------------------
// kfr_pkg: shared types and constants of the K-line frame receiver
// Holds the receive phase and frame status codes, the format byte masks,
// the configuration register indexes and the result item layout.
// ----------------------------------------------------------------------------
package kfr_pkg;

    // receive phase of the frame parser
    typedef enum logic [1:0] {
        PH_FORMAT = 2'd0,
        PH_TARGET = 2'd1,
        PH_SOURCE = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    // frame status as reported on the result stream
    typedef enum logic [1:0] {
        ST_RECV     = 2'd0,
        ST_OK       = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_LINE_ERR = 2'd3
    } t_status;

    // request on the input stream's tuser
    typedef enum logic {
        FN_BYTE  = 1'b0,
        FN_REARM = 1'b1
    } t_func;

    // configuration register indexes
    localparam logic CFG_TESTER_ADDR = 1'b0;
    localparam logic CFG_ECU_ADDR    = 1'b1;

    localparam logic [7:0] TESTER_ADDR_RST = 8'hF1;
    localparam logic [7:0] ECU_ADDR_RST    = 8'h10;

    // format byte: top two bits must read 10, low six bits carry the length
    localparam logic [7:0] FMT_MASK = 8'hC0;
    localparam logic [7:0] FMT_TAG  = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h3F;

    // one result item
    typedef struct packed {
        logic       reset_request;
        logic [7:0] payload_length;
        logic       store_valid;
        logic [7:0] stored_index;
        logic [7:0] stored_byte;
        t_status    frame_status;
    } t_result;

endpackage

// ===== design/kline_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// kline_frame_receiver: K-line diagnostic frame receiver
// Parses format, target, source, optional length, payload and checksum bytes
// one item at a time, writes payload bytes to a store and reports status.
// ----------------------------------------------------------------------------
// Output: a result appears on the master side in the cycle after its item is
//   accepted, held in a single output register.
// Throughput: one item per cycle; the parser state updates in the accept
//   cycle, and the slave side only stalls while the output register is full
//   and not being taken.
// Reset: synchronous, active low; clears the parser state and the output
//   valid and loads the address registers with 0xF1 and 0x10. The payload
//   store is not cleared and needs no clearing pass.
module kline_frame_receiver #(
    parameter int STORE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] line_error, [9] timed_out
    input  logic        s_axis_tuser,   // [0] func

    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] frame_status, [9:2] stored_byte,
                                        // [17:10] stored_index, [18] store_valid,
                                        // [26:19] payload_length, [27] reset_request
);

    localparam int AW = $clog2(STORE_DEPTH);

    // configuration
    logic [7:0] r_tester_addr;
    logic [7:0] r_ecu_addr;

    // parser state
    kfr_pkg::t_phase  r_phase,  n_phase;
    kfr_pkg::t_status r_status, n_status;
    logic [7:0]       r_sum,    n_sum;
    logic [7:0]       r_len,    n_len;
    logic [7:0]       r_count,  n_count;

    // output register
    logic              r_out_valid;
    kfr_pkg::t_result  r_out;
    kfr_pkg::t_result  n_out;

    // item fields
    logic       in_accept;
    logic       in_rearm;
    logic [7:0] in_byte;
    logic       in_lerr;
    logic       in_tmo;

    // decode helpers
    logic       active;
    logic       fmt_ok;
    logic       is_payload;
    logic       in_store;
    logic       wr_en;

    assign in_rearm = (kfr_pkg::t_func'(s_axis_tuser) == kfr_pkg::FN_REARM);
    assign in_byte  = s_axis_tdata[7:0];
    assign in_lerr  = s_axis_tdata[8];
    assign in_tmo   = s_axis_tdata[9];

    // take a new item whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // a received byte is only looked at while no status has been set
    assign active     = !in_rearm && (r_status == kfr_pkg::ST_RECV) && !in_lerr;
    assign fmt_ok     = ((in_byte & kfr_pkg::FMT_MASK) == kfr_pkg::FMT_TAG);
    assign is_payload = active && (r_phase == kfr_pkg::PH_BODY) && (r_len != 8'd0)
                        && (r_count != r_len);
    // drop writes past the end of the store but keep counting and summing
    assign in_store   = ({1'b0, r_count} < 9'(STORE_DEPTH));
    assign wr_en      = in_accept && is_payload && in_store;

    // ------------------------------------------------------------------
    // next phase
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        if (in_rearm) begin
            n_phase = kfr_pkg::PH_FORMAT;
        end else if (active) begin
            unique case (r_phase)
                kfr_pkg::PH_FORMAT: begin
                    if (fmt_ok) begin
                        n_phase = kfr_pkg::PH_TARGET;
                    end
                end
                kfr_pkg::PH_TARGET: begin
                    n_phase = (in_byte == r_tester_addr) ? kfr_pkg::PH_SOURCE
                                                         : kfr_pkg::PH_FORMAT;
                end
                kfr_pkg::PH_SOURCE: begin
                    n_phase = (in_byte == r_ecu_addr) ? kfr_pkg::PH_BODY
                                                      : kfr_pkg::PH_FORMAT;
                end
                kfr_pkg::PH_BODY: begin
                    n_phase = kfr_pkg::PH_BODY;
                end
                default: begin
                    n_phase = kfr_pkg::PH_FORMAT;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath: sum, length, count, status and the result item
    // ------------------------------------------------------------------
    always_comb begin
        n_sum    = r_sum;
        n_len    = r_len;
        n_count  = r_count;
        n_status = r_status;

        if (in_rearm) begin
            // leave the running sum alone, the next format byte reloads it
            n_len    = 8'd0;
            n_count  = 8'd0;
            n_status = kfr_pkg::ST_RECV;
        end else if (r_status == kfr_pkg::ST_RECV) begin
            if (in_lerr) begin
                n_status = kfr_pkg::ST_LINE_ERR;
            end else begin
                unique case (r_phase)
                    kfr_pkg::PH_FORMAT: begin
                        n_sum = in_byte;
                        if (fmt_ok) begin
                            n_len = in_byte & kfr_pkg::LEN_MASK;
                        end
                    end
                    kfr_pkg::PH_TARGET,
                    kfr_pkg::PH_SOURCE: begin
                        n_sum = r_sum + in_byte;
                    end
                    kfr_pkg::PH_BODY: begin
                        if (r_len == 8'd0) begin
                            // separate length byte; zero asks for another one
                            n_len = in_byte;
                            n_sum = r_sum + in_byte;
                        end else if (r_count == r_len) begin
                            n_status = (in_byte == r_sum) ? kfr_pkg::ST_OK
                                                          : kfr_pkg::ST_BAD_SUM;
                        end else begin
                            n_sum   = r_sum + in_byte;
                            n_count = r_count + 8'd1;
                        end
                    end
                    default: begin
                        n_sum = r_sum;
                    end
                endcase
            end
        end

        n_out.frame_status   = n_status;
        n_out.stored_byte    = wr_en ? in_byte : 8'd0;
        n_out.stored_index   = wr_en ? r_count : 8'd0;
        n_out.store_valid    = wr_en;
        n_out.payload_length = n_len;
        n_out.reset_request  = (n_status == kfr_pkg::ST_BAD_SUM)
                               || (n_status == kfr_pkg::ST_LINE_ERR) || in_tmo;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tester_addr <= kfr_pkg::TESTER_ADDR_RST;
            r_ecu_addr    <= kfr_pkg::ECU_ADDR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kfr_pkg::CFG_TESTER_ADDR: r_tester_addr <= i_cfg_data;
                kfr_pkg::CFG_ECU_ADDR:    r_ecu_addr    <= i_cfg_data;
                default:                  r_ecu_addr    <= r_ecu_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= kfr_pkg::PH_FORMAT;
            r_status <= kfr_pkg::ST_RECV;
            r_sum    <= 8'd0;
            r_len    <= 8'd0;
            r_count  <= 8'd0;
        end else if (in_accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_sum    <= n_sum;
            r_len    <= n_len;
            r_count  <= n_count;
        end
    end

    // output register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    // payload store; nothing downstream reads it back
    kfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_byte),
        .i_rd_addr (r_count[AW-1:0]),
        .o_rd_data ()
    );

endmodule

// ===== design/kfr_ram.sv =====
// ----------------------------------------------------------------------------
// kfr_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module kfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/kfr_checker.sv =====
// ----------------------------------------------------------------------------
// kfr_checker: port-level checks of the K-line frame receiver
// Watches the result stream for held payloads and consistent result fields.
// ----------------------------------------------------------------------------
module kfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // hold a stalled result unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an error status always raises the reset request
    a_err_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[27])
        else $error("error status without reset request");

    // a payload write only happens while the frame is still in progress
    a_store_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[1:0] == kfr_pkg::ST_RECV)
        else $error("payload stored with a final status");

    // no write: byte and index read zero
    a_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[17:2] == 16'd0)
        else $error("stored byte or index set without a write");

endmodule

bind kline_frame_receiver kfr_checker u_kfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/kline_frame_receiver_checker.sv =====
// ----------------------------------------------------------------------------
// kline_frame_receiver_checker: result checker of the K-line frame receiver
// Watches the configuration port and both streams, runs its own model of the
// frame parser on every accepted item and compares each result item, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------
module kline_frame_receiver_checker
    import kfr_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] line_error, [9] timed_out
    input  logic        s_axis_tuser,   // [0] func

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [1:0] frame_status, [9:2] stored_byte,
                                        // [17:10] stored_index, [18] store_valid,
                                        // [26:19] payload_length, [27] reset_request

    output int          o_results_due,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_W = $bits(t_result);

    // model copy of the parser state and the address registers
    t_phase     rx_phase;
    t_status    frame_state;
    logic [7:0] frame_sum;
    logic [7:0] frame_len;
    logic [7:0] body_count;
    logic [7:0] tester_addr;
    logic [7:0] ecu_addr;

    t_result    results_due[$];
    int         mismatches = 0;

    assign o_mismatches = mismatches;

    initial o_results_due = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch(name, 32'(got), 32'(want));
        end
    endtask

    // advance the parser model by one item and return the result it causes
    function automatic t_result parse_rx_item(t_func fn, logic [7:0] rx, logic lerr,
                                              logic tmo);
        t_result res;
        res = '0;
        if (fn == FN_REARM) begin
            rx_phase    = PH_FORMAT;
            body_count  = 8'd0;
            frame_len   = 8'd0;
            frame_state = ST_RECV;
        end else if (frame_state == ST_RECV) begin
            if (lerr) begin
                frame_state = ST_LINE_ERR;
            end else begin
                case (rx_phase)
                    PH_FORMAT: begin
                        frame_sum = rx;
                        if ((rx & FMT_MASK) == FMT_TAG) begin
                            frame_len = rx & LEN_MASK;
                            rx_phase  = PH_TARGET;
                        end
                    end
                    PH_TARGET: begin
                        frame_sum = frame_sum + rx;
                        rx_phase  = (rx == tester_addr) ? PH_SOURCE : PH_FORMAT;
                    end
                    PH_SOURCE: begin
                        frame_sum = frame_sum + rx;
                        rx_phase  = (rx == ecu_addr) ? PH_BODY : PH_FORMAT;
                    end
                    default: begin
                        if (frame_len == 8'd0) begin
                            // a zero length byte is followed by another one
                            frame_len = rx;
                            frame_sum = frame_sum + rx;
                        end else if (body_count == frame_len) begin
                            frame_state = (rx == frame_sum) ? ST_OK : ST_BAD_SUM;
                        end else begin
                            frame_sum = frame_sum + rx;
                            if (int'(body_count) < STORE_DEPTH) begin
                                res.store_valid  = 1'b1;
                                res.stored_byte  = rx;
                                res.stored_index = body_count;
                            end
                            body_count = body_count + 8'd1;
                        end
                    end
                endcase
            end
        end
        res.frame_status   = frame_state;
        res.payload_length = frame_len;
        res.reset_request  = (frame_state == ST_BAD_SUM) || (frame_state == ST_LINE_ERR)
                             || tmo;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            rx_phase    = PH_FORMAT;
            frame_state = ST_RECV;
            frame_sum   = 8'd0;
            frame_len   = 8'd0;
            body_count  = 8'd0;
            tester_addr = TESTER_ADDR_RST;
            ecu_addr    = ECU_ADDR_RST;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TESTER_ADDR) begin
                    tester_addr = i_cfg_data;
                end else if (i_cfg_index == CFG_ECU_ADDR) begin
                    ecu_addr = i_cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing expected", m_axis_tdata, '0);
                end else begin
                    want = results_due.pop_front();
                    got  = t_result'(m_axis_tdata[RESULT_W-1:0]);
                    compare_field("frame_status", 8'(got.frame_status),
                                  8'(want.frame_status));
                    compare_field("stored_byte", got.stored_byte, want.stored_byte);
                    compare_field("stored_index", got.stored_index, want.stored_index);
                    compare_field("store_valid", 8'(got.store_valid),
                                  8'(want.store_valid));
                    compare_field("payload_length", got.payload_length,
                                  want.payload_length);
                    compare_field("reset_request", 8'(got.reset_request),
                                  8'(want.reset_request));
                    compare_field("tdata padding", 8'(m_axis_tdata[31:RESULT_W]), 8'd0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(parse_rx_item(t_func'(s_axis_tuser),
                                                    s_axis_tdata[7:0], s_axis_tdata[8],
                                                    s_axis_tdata[9]));
            end
        end
        o_results_due <= results_due.size();
    end

endmodule

// ===== dv/kline_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// kline_frame_receiver_tb: testbench top of the K-line frame receiver
// Drives received bytes and re-arm items into the block: a short directed run
// over the special cases, then random frames, mostly well formed, under
// several address settings. Both stream sides idle at random and the result
// side holds off once for a long stretch. The checker compares every result.
// ----------------------------------------------------------------------------
module kline_frame_receiver_tb;
    import kfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_SETTING = 425;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_TESTER_ADDR;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;  // [7:0] rx_byte, [8] line_error, [9] timed_out
    logic        s_axis_tuser  = FN_BYTE; // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [1:0] frame_status, [9:2] stored_byte,
                                         // [17:10] stored_index, [18] store_valid,
                                         // [26:19] payload_length, [27] reset_request

    int          results_due;
    int          mismatches;

    // address settings the stimulus builds frames for
    logic [7:0]  tester_addr = TESTER_ADDR_RST;
    logic [7:0]  ecu_addr    = ECU_ADDR_RST;

    // frame under construction: running checksum, byte position, line error spot
    logic [7:0]  tx_sum;
    int          frame_pos;
    int          err_at;
    bit          frame_broken;

    int          items_counted = 0;
    int          burst_left    = 0;
    int          big_frames_left = 2;

    kline_frame_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kline_frame_receiver_checker #(
        .STORE_DEPTH (256)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_results_due (results_due),
        .o_mismatches  (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: the slowest legal run stays well below this.
    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Input-side idle gap: mostly none or short, a few long, and now and then
    // a burst of back-to-back items.
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic rand_timeout();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // Offer one item and hold it until the block takes it. Items the block
    // only ignores are not counted toward the random budget.
    task automatic push_item(t_func fn, logic [7:0] rx, logic lerr, logic tmo, bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {6'd0, tmo, lerr, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (counted) items_counted++;
    endtask

    task automatic push_rearm();
        push_item(FN_REARM, 8'($urandom), 1'($urandom), rand_timeout(), 1'b1);
    endtask

    task automatic begin_frame();
        tx_sum       = 8'd0;
        frame_pos    = 0;
        err_at       = -1;
        frame_broken = 1'b0;
    endtask

    // Send one frame byte and fold it into the checksum. At the chosen spot the
    // byte goes out with a line error instead, and the rest of the frame is
    // dropped.
    task automatic frame_byte(logic [7:0] b);
        if (!frame_broken) begin
            if (frame_pos == err_at) begin
                push_item(FN_BYTE, 8'($urandom), 1'b1, rand_timeout(), 1'b1);
                frame_broken = 1'b1;
            end else begin
                push_item(FN_BYTE, b, 1'b0, rand_timeout(), 1'b1);
                tx_sum = tx_sum + b;
            end
            frame_pos++;
        end
    endtask

    // Bytes sent while a status is held: the block must leave its state alone.
    task automatic push_strays();
        repeat ($urandom_range(0, 2)) begin
            push_item(FN_BYTE, 8'($urandom), 1'($urandom), rand_timeout(), 1'b0);
        end
    endtask

    // One complete frame after a re-arm: length in the format byte or in
    // separate length bytes (zero length bytes first), optional bad checksum
    // and an occasional line error somewhere in it.
    task automatic send_frame(int len, bit len_byte, int zero_lens, bit bad_sum);
        push_rearm();
        begin_frame();
        if ($urandom_range(0, 99) < 6) begin
            err_at = $urandom_range(0, 3 + zero_lens + int'(len_byte) + len);
        end
        frame_byte(len_byte ? FMT_TAG : (FMT_TAG | 8'(len)));
        frame_byte(tester_addr);
        frame_byte(ecu_addr);
        if (len_byte) begin
            repeat (zero_lens) frame_byte(8'd0);
            frame_byte(8'(len));
        end
        repeat (len) frame_byte(8'($urandom));
        frame_byte(bad_sum ? (tx_sum ^ 8'($urandom_range(1, 255))) : tx_sum);
        push_strays();
    endtask

    task automatic random_frame();
        int roll;
        int len;
        bit len_byte;
        int zero_lens;
        roll      = $urandom_range(0, 99);
        len_byte  = 1'b0;
        zero_lens = 0;
        if (roll < 60) begin
            len = $urandom_range(1, 12);
        end else if (roll < 70) begin
            len = ($urandom_range(0, 2) == 0) ? 63 : $urandom_range(13, 63);
        end else if (roll < 97 || big_frames_left == 0) begin
            len_byte  = 1'b1;
            len       = $urandom_range(1, 20);
            zero_lens = $urandom_range(0, 2);
        end else begin
            // only a couple of long bodies, the first at the full byte range
            len_byte = 1'b1;
            len      = (big_frames_left == 2) ? 255 : $urandom_range(128, 254);
            big_frames_left--;
        end
        send_frame(len, len_byte, zero_lens, $urandom_range(0, 99) < 15);
    endtask

    task automatic random_noise();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: begin
                // format byte whose top bits are not 10
                b = 8'($urandom);
                b[7:6] = ($urandom_range(0, 2) == 0) ? 2'b00 :
                         ($urandom_range(0, 1) == 0) ? 2'b01 : 2'b11;
                push_item(FN_BYTE, b, 1'b0, rand_timeout(), 1'b1);
            end
            1: begin
                // address miss on target or on source, then loose bytes
                push_rearm();
                begin_frame();
                frame_byte(FMT_TAG | (8'($urandom) & LEN_MASK));
                if ($urandom_range(0, 1) == 0) begin
                    frame_byte(tester_addr ^ 8'($urandom_range(1, 255)));
                end else begin
                    frame_byte(tester_addr);
                    frame_byte(ecu_addr ^ 8'($urandom_range(1, 255)));
                end
                repeat ($urandom_range(0, 3)) frame_byte(8'($urandom));
            end
            2: begin
                // fully random items
                repeat ($urandom_range(1, 6)) begin
                    push_item(($urandom_range(0, 9) == 0) ? FN_REARM : FN_BYTE,
                              8'($urandom), $urandom_range(0, 6) == 0, rand_timeout(),
                              1'b1);
                end
            end
            default: begin
                // body cut short, then re-armed
                push_rearm();
                begin_frame();
                frame_byte(FMT_TAG | 8'($urandom_range(4, 20)));
                frame_byte(tester_addr);
                frame_byte(ecu_addr);
                repeat ($urandom_range(0, 3)) frame_byte(8'($urandom));
                push_rearm();
            end
        endcase
    endtask

    task automatic run_random(int budget);
        int stop_at;
        stop_at = items_counted + budget;
        while (items_counted < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                random_frame();
            end else begin
                random_noise();
            end
        end
    endtask

    // Drop valid, then wait until every expected result has come back, plus
    // the single register stage of the block.
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write both address registers while the block is idle.
    task automatic load_addresses(logic [7:0] tester, logic [7:0] ecu);
        tester_addr = tester;
        ecu_addr    = ecu;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TESTER_ADDR;
        i_cfg_data  <= tester;
        @(posedge i_clk);
        i_cfg_index <= CFG_ECU_ADDR;
        i_cfg_data  <= ecu;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: random ready with short and long stalls, stretches of
    // steady ready, and one long hold-off so that the output register fills and
    // the input side stalls.
    initial begin : result_sink
        int span;
        int results_taken;
        bit hold_done;
        results_taken = 0;
        hold_done     = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && results_taken > 400) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
            repeat (span) begin
                @(posedge i_clk);
                if (m_axis_tvalid && m_axis_tready) results_taken++;
            end
            m_axis_tready <= 1'b0;
            span = $urandom_range(0, 99);
            span = (span < 70) ? $urandom_range(1, 2) :
                   (span < 95) ? $urandom_range(3, 8) : $urandom_range(20, 60);
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part at the reset addresses.
        // Good frame with payload bytes at both extremes.
        begin_frame();
        frame_byte(FMT_TAG | 8'd2);
        frame_byte(tester_addr);
        frame_byte(ecu_addr);
        frame_byte(8'h00);
        frame_byte(8'hFF);
        frame_byte(tx_sum);
        // Status held: a byte with line error and timeout changes nothing.
        push_item(FN_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1);
        push_item(FN_REARM, 8'hFF, 1'b1, 1'b0, 1'b1);
        // Bad format bytes keep the parser waiting for a format byte.
        push_item(FN_BYTE, 8'hC0, 1'b0, 1'b0, 1'b1);
        push_item(FN_BYTE, 8'h3F, 1'b0, 1'b0, 1'b1);
        // Separate length byte, a zero one first, and a wrong checksum.
        begin_frame();
        frame_byte(FMT_TAG);
        frame_byte(tester_addr);
        frame_byte(ecu_addr);
        frame_byte(8'h00);
        frame_byte(8'h01);
        frame_byte(8'hAB);
        frame_byte(~tx_sum);
        push_item(FN_REARM, 8'h00, 1'b0, 1'b1, 1'b1);
        // Source address miss, then longest format length with a target miss.
        begin_frame();
        frame_byte(FMT_TAG | 8'd1);
        frame_byte(tester_addr);
        frame_byte(ecu_addr ^ 8'h01);
        frame_byte(8'hBF);
        frame_byte(tester_addr ^ 8'h80);
        // Line error while waiting for a format byte.
        push_item(FN_BYTE, 8'h55, 1'b1, 1'b0, 1'b1);
        push_item(FN_REARM, 8'h00, 1'b0, 1'b0, 1'b1);
        settle();

        // Random part across several address settings, extremes first.
        load_addresses(8'h00, 8'hFF);
        run_random(ITEMS_PER_SETTING);
        settle();
        load_addresses(8'hFF, 8'h00);
        run_random(ITEMS_PER_SETTING);
        settle();
        load_addresses(8'($urandom), 8'($urandom));
        run_random(ITEMS_PER_SETTING);
        settle();
        tester_addr = 8'($urandom);
        load_addresses(tester_addr, tester_addr);
        run_random(ITEMS_PER_SETTING);
        settle();

        if (mismatches == 0 && results_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
